/* hw/rtl/rws_pkg.sv */
// Shared types and constants of the rational waveshaper mix block.
// Used by rws_div and rational_waveshaper_mix; depends on nothing.
`default_nettype none

package rws_pkg;

	// register map
	typedef enum logic [2:0] {
		REG_DRIVE_GAIN   = 3'd0,
		REG_OUTPUT_GAIN  = 3'd1,
		REG_SHAPE_AMOUNT = 3'd2,
		REG_PRE_BIAS     = 3'd3,
		REG_POST_BIAS    = 3'd4,
		REG_WET_FRACTION = 3'd5
	} reg_idx_t;

	localparam int REG_IDX_W = 3;
	localparam int REG_W     = 16;

	localparam logic [REG_W-1:0] DRIVE_GAIN_RST   = 16'd4096;
	localparam logic [REG_W-1:0] OUTPUT_GAIN_RST  = 16'd4096;
	localparam logic [REG_W-1:0] SHAPE_AMOUNT_RST = 16'd0;
	localparam logic [REG_W-1:0] PRE_BIAS_RST     = 16'd0;
	localparam logic [REG_W-1:0] POST_BIAS_RST    = 16'd0;
	localparam logic [REG_W-1:0] WET_FRACTION_RST = 16'd32768;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_SAT      = 2'd1;
	localparam logic [1:0] ST_ZERO_DEN = 2'd2;

	// fixed-point formats
	localparam int XFRAC     = 16;
	localparam int GAIN_FRAC = 12;
	localparam logic [REG_W-1:0] WET_ONE       = 16'd32768;
	localparam logic [REG_W-1:0] SHAPE_NEG_ONE = 16'h8000;

	// datapath widths
	localparam int SX_W  = 18;	// aligned sample, Q.16
	localparam int T_W   = 19;	// biased sample
	localparam int P_W   = 36;	// drive product
	localparam int X_W   = 24;	// shaper input, Q.16
	localparam int AX_W  = 23;	// |x|
	localparam int K_W   = 18;	// k16 - 1.0
	localparam int NUM_W = 48;	// numerator, Q.32
	localparam int AN_W  = 47;	// |numerator|
	localparam int LIN_W = 42;	// (k-1)|x| term
	localparam int DEN_W = 46;	// denominator, Q.32, never negative
	localparam int Q_W   = 37;	// quotient, Q.16, clamped to 2^(Q_W-1)

	localparam int DIV_LAT = Q_W + 2;

	typedef struct packed {
		logic valid;
		logic neg;
		logic zero;
	} ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/rws_div.sv */
// Pipelined restoring divider: quotient = (dividend << XFRAC) / divisor,
// one quotient bit per stage, clamped to 2^(Q_W-1). Depends on rws_pkg.
`default_nettype none

module rws_div #(
	parameter int TAG_W = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire rws_pkg::ctl_t             src_ctl,
	input  wire logic [rws_pkg::AN_W-1:0]  dividend,
	input  wire logic [rws_pkg::DEN_W-1:0] divisor,
	input  wire logic [TAG_W-1:0]          src_tag,
	output rws_pkg::ctl_t                  res_ctl,
	output logic [rws_pkg::Q_W-1:0]        quotient,
	output logic [TAG_W-1:0]               res_tag
);

	localparam int QW   = rws_pkg::Q_W;
	localparam int DW   = rws_pkg::DEN_W;
	localparam int N_W  = rws_pkg::AN_W + rws_pkg::XFRAC;
	localparam int LAST = QW + 1;
	localparam logic [QW-1:0] Q_LIM = QW'(1) << (QW - 1);

	rws_pkg::ctl_t   ctl_s [0:LAST];
	logic [TAG_W-1:0] tag_s [0:LAST];
	logic [QW-1:0]   quo_s [0:LAST];
	logic [DW-1:0]   rem_s [0:QW];
	logic [QW-1:0]   lo_s  [0:QW];
	logic [DW-1:0]   den_s [0:QW];
	logic            ovf_s [0:QW];

	logic [N_W-1:0] num_full;

	assign num_full = {dividend, {rws_pkg::XFRAC{1'b0}}};

	// entry: top bits seed the remainder; quotient overflows if they reach the divisor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else begin
			ctl_s[0] <= src_ctl;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= DW'(num_full[N_W-1:QW]);
		lo_s[0]  <= num_full[QW-1:0];
		den_s[0] <= divisor;
		ovf_s[0] <= (DW'(num_full[N_W-1:QW]) >= divisor);
		quo_s[0] <= '0;
		tag_s[0] <= src_tag;
	end

	for (genvar i = 0; i < QW; i++) begin : g_step
		logic [DW:0] trial;
		logic [DW:0] diff;
		logic        ge;

		assign trial = {rem_s[i], lo_s[i][QW-1]};
		assign diff  = trial - {1'b0, den_s[i]};
		assign ge    = (trial >= {1'b0, den_s[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[i+1] <= '0;
			end else begin
				ctl_s[i+1] <= ctl_s[i];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
			lo_s[i+1]  <= lo_s[i] << 1;
			quo_s[i+1] <= {quo_s[i][QW-2:0], ge};
			den_s[i+1] <= den_s[i];
			ovf_s[i+1] <= ovf_s[i];
			tag_s[i+1] <= tag_s[i];
		end
	end

	// clamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[LAST] <= '0;
		end else begin
			ctl_s[LAST] <= ctl_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		quo_s[LAST] <= (ovf_s[QW] || (quo_s[QW] > Q_LIM)) ? Q_LIM : quo_s[QW];
		tag_s[LAST] <= tag_s[QW];
	end

	assign res_ctl  = ctl_s[LAST];
	assign quotient = quo_s[LAST];
	assign res_tag  = tag_s[LAST];

endmodule

`default_nettype wire

/* hw/rtl/rational_waveshaper_mix.sv */
// Rational waveshaper with dry/wet mix, fully pipelined fixed-point datapath.
// Depends on rws_pkg and rws_div.
//
// Usage:
//   Samples enter on audio_in; a sample is taken at a rising edge with start
//   high and busy low. busy is high only in the first cycle after reset, so
//   a new sample may enter in every cycle.
//   Each sample yields one result: audio_out and status are valid for the
//   single cycle in which done is high, after the sample has passed 5 front
//   stages, a 39-stage divider and 6 back stages. The receiver
//   cannot hold results off; results come out in input order.
//   Throughput is one sample per cycle; the divider resolves one quotient bit
//   per stage. Registers are written through wr_en / wr_index / wr_data;
//   unknown indexes are ignored. The user must write them only while no
//   sample is in flight; the block itself does not enforce this.
//   Reset clears all valid bits (no result is emitted for samples in flight)
//   and returns the registers to unity gains, zero shape and bias, full wet.
//   status: ST_OK, ST_SAT (audio_out clipped), ST_ZERO_DEN (k = -1, |x| = 1).
`default_nettype none

module rational_waveshaper_mix #(
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic signed [SAMPLE_BITS-1:0] audio_in,
	output logic                              done,
	output logic signed [SAMPLE_BITS-1:0]     audio_out,
	output logic [1:0]                        status,
	input  wire logic                         wr_en,
	input  wire logic [rws_pkg::REG_IDX_W-1:0] wr_index,
	input  wire logic [rws_pkg::REG_W-1:0]    wr_data
);

	localparam int F      = SAMPLE_BITS - 1;
	localparam int G      = (F > rws_pkg::XFRAC) ? F : rws_pkg::XFRAC;
	localparam int SH     = G + 15 - F;
	localparam int ACC_W  = G + 34;
	localparam int RES_W  = ACC_W - SH;
	localparam int DRY_W  = SAMPLE_BITS + 17;
	localparam int M_W    = rws_pkg::Q_W + rws_pkg::REG_W;
	localparam int MR_W   = M_W + 1;
	localparam int RM_W   = 33;
	localparam int WM_W   = RM_W + rws_pkg::REG_W;
	localparam int LATENCY = 5 + rws_pkg::DIV_LAT + 6;

	localparam logic signed [rws_pkg::P_W-1:0] P_RND =
		rws_pkg::P_W'(1 << (rws_pkg::GAIN_FRAC - 1));
	localparam logic [MR_W-1:0] M_RND = MR_W'(1 << (rws_pkg::GAIN_FRAC - 1));
	localparam logic [RM_W-1:0] RM_LIM = RM_W'(1) << (RM_W - 1);
	localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(64'sd1 <<< (SH - 1));
	localparam logic signed [RES_W-1:0] LIM_HI = RES_W'((64'sd1 <<< F) - 64'sd1);
	localparam logic signed [RES_W-1:0] LIM_LO = RES_W'(-(64'sd1 <<< F));
	localparam logic signed [rws_pkg::K_W-1:0] K_ONE =
		rws_pkg::K_W'(1 << rws_pkg::XFRAC);
	localparam logic signed [rws_pkg::NUM_W-1:0] DEN_ONE =
		rws_pkg::NUM_W'(64'sd1 <<< (2 * rws_pkg::XFRAC));
	localparam logic [rws_pkg::AX_W-1:0] X_ONE = rws_pkg::AX_W'(1 << rws_pkg::XFRAC);

	// configuration registers
	logic [rws_pkg::REG_W-1:0] drive_gain_q, output_gain_q, shape_amount_q;
	logic [rws_pkg::REG_W-1:0] pre_bias_q, post_bias_q, wet_fraction_q;
	logic                      busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_gain_q   <= rws_pkg::DRIVE_GAIN_RST;
			output_gain_q  <= rws_pkg::OUTPUT_GAIN_RST;
			shape_amount_q <= rws_pkg::SHAPE_AMOUNT_RST;
			pre_bias_q     <= rws_pkg::PRE_BIAS_RST;
			post_bias_q    <= rws_pkg::POST_BIAS_RST;
			wet_fraction_q <= rws_pkg::WET_FRACTION_RST;
		end else if (wr_en) begin
			unique case (rws_pkg::reg_idx_t'(wr_index))
				rws_pkg::REG_DRIVE_GAIN:   drive_gain_q   <= wr_data;
				rws_pkg::REG_OUTPUT_GAIN:  output_gain_q  <= wr_data;
				rws_pkg::REG_SHAPE_AMOUNT: shape_amount_q <= wr_data;
				rws_pkg::REG_PRE_BIAS:     pre_bias_q     <= wr_data;
				rws_pkg::REG_POST_BIAS:    post_bias_q    <= wr_data;
				rws_pkg::REG_WET_FRACTION: wet_fraction_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy = busy_q;

	logic [rws_pkg::REG_W-1:0] wet_c, dry_c;

	assign wet_c = (wet_fraction_q > rws_pkg::WET_ONE) ? rws_pkg::WET_ONE : wet_fraction_q;
	assign dry_c = rws_pkg::WET_ONE - wet_c;

	// S1: align sample to Q.16, add pre-bias
	logic signed [rws_pkg::SX_W-1:0] sx;
	logic signed [rws_pkg::T_W-1:0]  t_in;

	if (F <= rws_pkg::XFRAC) begin : g_align_up
		assign sx = rws_pkg::SX_W'(audio_in) <<< (rws_pkg::XFRAC - F);
	end else begin : g_align_down
		localparam int RW = SAMPLE_BITS + 1;
		logic signed [RW-1:0] s_rnd;
		assign s_rnd = RW'(audio_in) + RW'(1 << (F - rws_pkg::XFRAC - 1));
		assign sx    = rws_pkg::SX_W'(s_rnd >>> (F - rws_pkg::XFRAC));
	end

	assign t_in = rws_pkg::T_W'(sx) + (rws_pkg::T_W'(signed'(pre_bias_q)) <<< 1);

	logic                            v_s1, v_s2, v_s3, v_s4;
	logic signed [rws_pkg::T_W-1:0]  t_s1;
	logic signed [SAMPLE_BITS-1:0]   sample_s1, sample_s2, sample_s3, sample_s4, sample_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start && !busy_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		t_s1      <= t_in;
		sample_s1 <= audio_in;
	end

	// S2: drive
	logic signed [rws_pkg::P_W-1:0] p_s2;

	always_ff @(posedge clk) begin
		p_s2      <= t_s1 * signed'({1'b0, drive_gain_q});
		sample_s2 <= sample_s1;
	end

	// S3: round, post-bias
	logic signed [rws_pkg::X_W-1:0] x_s3;

	always_ff @(posedge clk) begin
		x_s3 <= rws_pkg::X_W'((p_s2 + P_RND) >>> rws_pkg::GAIN_FRAC)
			+ (rws_pkg::X_W'(signed'(post_bias_q)) <<< 1);
		sample_s3 <= sample_s2;
	end

	// S4: numerator and denominator products
	logic signed [rws_pkg::X_W-1:0]   ax, ax_k;
	logic [rws_pkg::AX_W-1:0]         ax_u;
	logic signed [rws_pkg::K_W-1:0]   k_m1;
	logic signed [rws_pkg::NUM_W-1:0] num_s4;
	logic [rws_pkg::DEN_W-1:0]        sq_s4;
	logic signed [rws_pkg::LIN_W-1:0] lin_s4;
	logic                             zero_s4;

	assign ax   = x_s3[rws_pkg::X_W-1] ? -x_s3 : x_s3;
	assign ax_u = ax[rws_pkg::AX_W-1:0];
	assign ax_k = signed'({1'b0, ax_u}) + (rws_pkg::X_W'(signed'(shape_amount_q)) <<< 1);
	assign k_m1 = (rws_pkg::K_W'(signed'(shape_amount_q)) <<< 1) - K_ONE;

	always_ff @(posedge clk) begin
		num_s4    <= x_s3 * ax_k;
		sq_s4     <= ax_u * ax_u;
		lin_s4    <= k_m1 * signed'({1'b0, ax_u});
		zero_s4   <= (shape_amount_q == rws_pkg::SHAPE_NEG_ONE) && (ax_u == X_ONE);
		sample_s4 <= sample_s3;
	end

	// S5: denominator sum, numerator magnitude
	logic signed [rws_pkg::NUM_W-1:0] den_sum, num_mag;
	rws_pkg::ctl_t                    ctl_s5;
	logic [rws_pkg::AN_W-1:0]         an_s5;
	logic [rws_pkg::DEN_W-1:0]        den_s5;

	assign den_sum = signed'({2'b00, sq_s4}) + rws_pkg::NUM_W'(lin_s4) + DEN_ONE;
	assign num_mag = num_s4[rws_pkg::NUM_W-1] ? -num_s4 : num_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s5 <= '0;
		end else begin
			ctl_s5.valid <= v_s4;
			ctl_s5.neg   <= num_s4[rws_pkg::NUM_W-1];
			ctl_s5.zero  <= zero_s4;
		end
	end

	always_ff @(posedge clk) begin
		an_s5     <= num_mag[rws_pkg::AN_W-1:0];
		den_s5    <= den_sum[rws_pkg::DEN_W-1:0];
		sample_s5 <= sample_s4;
	end

	// S6..S44: divider
	rws_pkg::ctl_t                 ctl_s44;
	logic [rws_pkg::Q_W-1:0]       q_s44;
	logic signed [SAMPLE_BITS-1:0] sample_s44;

	rws_div #(
		.TAG_W(SAMPLE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_ctl  (ctl_s5),
		.dividend (an_s5),
		.divisor  (den_s5),
		.src_tag  (sample_s5),
		.res_ctl  (ctl_s44),
		.quotient (q_s44),
		.res_tag  (sample_s44)
	);

	// S45: output gain
	rws_pkg::ctl_t                 ctl_s45, ctl_s46, ctl_s47, ctl_s48, ctl_s49;
	logic [M_W-1:0]                m_s45;
	logic signed [SAMPLE_BITS-1:0] sample_s45;

	always_ff @(posedge clk) begin
		m_s45      <= q_s44 * output_gain_q;
		sample_s45 <= sample_s44;
	end

	// S46: round magnitude (half up in signed terms), clamp, zero on a zero denominator; dry product
	logic [MR_W-1:0]               m_rnd;
	logic [MR_W-rws_pkg::GAIN_FRAC-1:0] m_sh;
	logic [RM_W-1:0]               rm_s46;
	logic signed [DRY_W-1:0]       dry_s46, dry_s47, dry_s48;

	assign m_rnd = MR_W'(m_s45) + M_RND - MR_W'(ctl_s45.neg);
	assign m_sh  = m_rnd[MR_W-1:rws_pkg::GAIN_FRAC];

	always_ff @(posedge clk) begin
		if (ctl_s45.zero) begin
			rm_s46 <= '0;
		end else if (m_sh > (MR_W-rws_pkg::GAIN_FRAC)'(RM_LIM)) begin
			rm_s46 <= RM_LIM;
		end else begin
			rm_s46 <= m_sh[RM_W-1:0];
		end
		dry_s46 <= signed'({1'b0, dry_c}) * sample_s45;
	end

	// S47: wet product
	logic [WM_W-1:0] wm_s47;

	always_ff @(posedge clk) begin
		wm_s47  <= rm_s46 * wet_c;
		dry_s47 <= dry_s46;
	end

	// S48: apply sign
	logic signed [WM_W:0] wet_s48;

	always_ff @(posedge clk) begin
		wet_s48 <= ctl_s47.neg ? -signed'({1'b0, wm_s47}) : signed'({1'b0, wm_s47});
		dry_s48 <= dry_s47;
	end

	// S49: mix and round
	logic signed [ACC_W-1:0] acc;
	logic signed [RES_W-1:0] res_s49;

	assign acc = (ACC_W'(wet_s48) <<< (G - rws_pkg::XFRAC))
		+ (ACC_W'(dry_s48) <<< (G - F)) + ACC_RND;

	always_ff @(posedge clk) begin
		res_s49 <= RES_W'(acc >>> SH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s45 <= '0;
			ctl_s46 <= '0;
			ctl_s47 <= '0;
			ctl_s48 <= '0;
			ctl_s49 <= '0;
		end else begin
			ctl_s45 <= ctl_s44;
			ctl_s46 <= ctl_s45;
			ctl_s47 <= ctl_s46;
			ctl_s48 <= ctl_s47;
			ctl_s49 <= ctl_s48;
		end
	end

	// S50: saturate, status
	logic                          done_s50;
	logic signed [SAMPLE_BITS-1:0] audio_out_s50;
	logic [1:0]                    status_s50;
	logic                          sat_hi, sat_lo;

	assign sat_hi = (res_s49 > LIM_HI);
	assign sat_lo = (res_s49 < LIM_LO);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s50 <= 1'b0;
		end else begin
			done_s50 <= ctl_s49.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sat_hi) begin
			audio_out_s50 <= LIM_HI[SAMPLE_BITS-1:0];
		end else if (sat_lo) begin
			audio_out_s50 <= LIM_LO[SAMPLE_BITS-1:0];
		end else begin
			audio_out_s50 <= res_s49[SAMPLE_BITS-1:0];
		end
		if (sat_hi || sat_lo) begin
			status_s50 <= rws_pkg::ST_SAT;
		end else if (ctl_s49.zero) begin
			status_s50 <= rws_pkg::ST_ZERO_DEN;
		end else begin
			status_s50 <= rws_pkg::ST_OK;
		end
	end

	assign done      = done_s50;
	assign audio_out = audio_out_s50;
	assign status    = status_s50;

	// every transfer yields exactly one result
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("result missing after transfer");

	a_latency_bwd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a matching transfer");

	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == rws_pkg::ST_SAT) |->
		(audio_out == LIM_HI[SAMPLE_BITS-1:0] || audio_out == LIM_LO[SAMPLE_BITS-1:0]))
		else $error("saturation flagged off the rails");

	a_zero_full_wet: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == rws_pkg::ST_ZERO_DEN && wet_fraction_q >= rws_pkg::WET_ONE)
		|-> (audio_out == '0))
		else $error("zero denominator with full wet gave nonzero output");

endmodule

`default_nettype wire
